@@ design/mcpi_pkg.sv @@
// Package: shared types and constants for the multi-channel PI position controller.
`default_nettype none

package mcpi_pkg;

    // Number of hardware lanes (channels carried by one word)
    localparam int LANES      = 4;
    localparam int POS_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int CLAMP_W    = 32;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 2 * LANES * POS_W;
    localparam int OUT_DATA_W = LANES * DUTY_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_INTEG_UPPER   = 3'd2,
        REG_INTEG_LOWER   = 3'd3,
        REG_PERIOD_LEN    = 3'd4
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0]          PROP_GAIN_RST     = 16'd16384;
    localparam logic [GAIN_W-1:0]          INTEGRAL_GAIN_RST = 16'd328;
    localparam logic signed [CLAMP_W-1:0]  INTEG_UPPER_RST   = 32'sd16777216;
    localparam logic signed [CLAMP_W-1:0]  INTEG_LOWER_RST   = -32'sd16777216;
    localparam logic [PERIOD_W-1:0]        PERIOD_LEN_RST    = 16'd1024;

    // Stage load strobes shared by all lanes
    typedef struct packed {
        logic load_prod;   // stage 0: error products
        logic load_acc;    // stage 1: integrator sum and clamp
        logic load_ctl;    // stage 2: scaled control value
        logic load_out;    // stage 3: merged output word
        logic integ_upd;   // integrator takes the clamped sum
    } lane_ctrl_t;

endpackage

`default_nettype wire

@@ design/multi_channel_pi_position_controller.sv @@
// Multi-channel PI position controller: config registers, lanes and merged output word.
//
// Usage:
//   Each input word on s_axis is one control tick with a target and a measured
//   position for every channel. The block returns one output word on m_axis
//   with the PWM duty value of every channel (channels at or above CHANNELS
//   report 0). Gains, integrator clamps and the PWM period are set through the
//   cfg_wr_en / cfg_index / cfg_data write port while no word is in flight.
// Stages and throughput:
//   Four register stages: products, integrator, scaling, merged output.
//   A word is registered in each stage in turn before m_axis_tvalid rises for it;
//   one word per cycle is sustained while m_axis_tready stays high. The
//   per-channel integrator update (add and clamp) is combinational from the
//   integrator register, which sets that rate.
// Reset:
//   rst_n clears the pipeline, zeroes all integrators and loads the default
//   configuration.
// Stalls:
//   When m_axis_tready is low the output word holds; empty stages upstream
//   keep filling, and s_axis_tready drops only when every stage is occupied.
`default_nettype none

module multi_channel_pi_position_controller #(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [mcpi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcpi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: target_0, target_1, target_2, target_3,
    // measured_0, measured_1, measured_2, measured_3 (12 bits each)
    input  logic [mcpi_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0: duty_0, duty_1, duty_2, duty_3 (16 bits each)
    output logic [mcpi_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int POS_W  = mcpi_pkg::POS_W;
    localparam int DUTY_W = mcpi_pkg::DUTY_W;
    localparam int LANES  = mcpi_pkg::LANES;

    // Configuration registers
    logic [mcpi_pkg::GAIN_W-1:0]          prop_gain_reg;
    logic [mcpi_pkg::GAIN_W-1:0]          integral_gain_reg;
    logic signed [mcpi_pkg::CLAMP_W-1:0]  integ_upper_reg;
    logic signed [mcpi_pkg::CLAMP_W-1:0]  integ_lower_reg;
    logic [mcpi_pkg::PERIOD_W-1:0]        period_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= mcpi_pkg::PROP_GAIN_RST;
            integral_gain_reg <= mcpi_pkg::INTEGRAL_GAIN_RST;
            integ_upper_reg   <= mcpi_pkg::INTEG_UPPER_RST;
            integ_lower_reg   <= mcpi_pkg::INTEG_LOWER_RST;
            period_len_reg    <= mcpi_pkg::PERIOD_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mcpi_pkg::REG_PROP_GAIN:
                begin
                    prop_gain_reg <= cfg_data[mcpi_pkg::GAIN_W-1:0];
                end
                mcpi_pkg::REG_INTEGRAL_GAIN:
                begin
                    integral_gain_reg <= cfg_data[mcpi_pkg::GAIN_W-1:0];
                end
                mcpi_pkg::REG_INTEG_UPPER:
                begin
                    integ_upper_reg <= $signed(cfg_data[mcpi_pkg::CLAMP_W-1:0]);
                end
                mcpi_pkg::REG_INTEG_LOWER:
                begin
                    integ_lower_reg <= $signed(cfg_data[mcpi_pkg::CLAMP_W-1:0]);
                end
                mcpi_pkg::REG_PERIOD_LEN:
                begin
                    period_len_reg <= cfg_data[mcpi_pkg::PERIOD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Handshake and stage strobes
    mcpi_pkg::lane_ctrl_t lane_ctrl;

    mcpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .lane_ctrl (lane_ctrl)
    );

    // Lanes: active channels get a controller, the rest report 0
    logic [DUTY_W-1:0] lane_duty [LANES];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < CHANNELS)
        begin : g_active
            mcpi_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (lane_ctrl),
                .target        (s_axis_tdata[i*POS_W +: POS_W]),
                .measured      (s_axis_tdata[(LANES + i)*POS_W +: POS_W]),
                .prop_gain     (prop_gain_reg),
                .integral_gain (integral_gain_reg),
                .integ_upper   (integ_upper_reg),
                .integ_lower   (integ_lower_reg),
                .period_len    (period_len_reg),
                .duty          (lane_duty[i])
            );
        end
        else
        begin : g_idle
            assign lane_duty[i] = '0;
        end
    end

    // Merge stage: pack lane duties into the output word register
    logic [mcpi_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [mcpi_pkg::OUT_DATA_W-1:0] out_data_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            out_data_next[i*DUTY_W +: DUTY_W] = lane_duty[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctrl.load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tdata = out_data_reg;

endmodule

`default_nettype wire

@@ design/mcpi_lane.sv @@
// One controller lane: error products, clamped integrator, scaling and duty clamp.
`default_nettype none

module mcpi_lane #(
    parameter int FRAC_BITS = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mcpi_pkg::lane_ctrl_t                 ctrl,
    input  logic [mcpi_pkg::POS_W-1:0]           target,
    input  logic [mcpi_pkg::POS_W-1:0]           measured,
    input  logic [mcpi_pkg::GAIN_W-1:0]          prop_gain,
    input  logic [mcpi_pkg::GAIN_W-1:0]          integral_gain,
    input  logic signed [mcpi_pkg::CLAMP_W-1:0]  integ_upper,
    input  logic signed [mcpi_pkg::CLAMP_W-1:0]  integ_lower,
    input  logic [mcpi_pkg::PERIOD_W-1:0]        period_len,
    output logic [mcpi_pkg::DUTY_W-1:0]          duty
);

    localparam int ERR_W  = mcpi_pkg::POS_W + 1;
    localparam int PROD_W = mcpi_pkg::GAIN_W + 1 + ERR_W;
    localparam int SUM_W  = mcpi_pkg::CLAMP_W + 1;
    localparam int LVL_W  = SUM_W + 1;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Stage 0: error and the two gain products
    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prop_next;
    logic signed [PROD_W-1:0] iprod_next;
    logic signed [PROD_W-1:0] prop0_reg;
    logic signed [PROD_W-1:0] iprod0_reg;

    assign err        = $signed({1'b0, target}) - $signed({1'b0, measured});
    assign prop_next  = $signed({1'b0, prop_gain}) * err;
    assign iprod_next = $signed({1'b0, integral_gain}) * err;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prop0_reg  <= prop_next;
            iprod0_reg <= iprod_next;
        end
    end

    // Stage 1: integrator add with anti-windup clamp (upper tested first)
    logic signed [mcpi_pkg::CLAMP_W-1:0] integ_reg;
    logic signed [mcpi_pkg::CLAMP_W-1:0] integ_next;
    logic signed [SUM_W-1:0]             acc_sum;
    logic signed [PROD_W-1:0]            prop1_reg;
    logic signed [mcpi_pkg::CLAMP_W-1:0] acc1_reg;

    assign acc_sum = SUM_W'(integ_reg) + SUM_W'(iprod0_reg);

    always_comb
    begin
        if (acc_sum > SUM_W'(integ_upper))
        begin
            integ_next = integ_upper;
        end
        else if (acc_sum < SUM_W'(integ_lower))
        begin
            integ_next = integ_lower;
        end
        else
        begin
            integ_next = acc_sum[mcpi_pkg::CLAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (ctrl.integ_upd)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_acc)
        begin
            prop1_reg <= prop0_reg;
            acc1_reg  <= integ_next;
        end
    end

    // Stage 2: sum and divide by 2^FRAC_BITS, truncating toward zero
    logic signed [SUM_W-1:0] pi_sum;
    logic signed [SUM_W-1:0] pi_biased;
    logic signed [SUM_W-1:0] ctl_next;
    logic signed [SUM_W-1:0] ctl_reg;

    assign pi_sum    = SUM_W'(prop1_reg) + SUM_W'(acc1_reg);
    assign pi_biased = pi_sum[SUM_W-1] ? (pi_sum + RND) : pi_sum;
    assign ctl_next  = pi_biased >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_ctl)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Centering on half the period and clamp to 0..period-1
    logic signed [LVL_W-1:0] level;
    logic signed [LVL_W-1:0] period_ext;

    assign period_ext = $signed({{(LVL_W - mcpi_pkg::PERIOD_W){1'b0}}, period_len});
    assign level      = LVL_W'(ctl_reg)
                      + $signed({{(LVL_W - mcpi_pkg::PERIOD_W + 1){1'b0}},
                                 period_len[mcpi_pkg::PERIOD_W-1:1]});

    always_comb
    begin
        if (period_len == '0)
        begin
            duty = '0;
        end
        else if (level >= period_ext)
        begin
            duty = period_len - 1'b1;
        end
        else if (level < LVL_W'(1))
        begin
            duty = '0;
        end
        else
        begin
            duty = level[mcpi_pkg::DUTY_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ design/mcpi_ctrl.sv @@
// Pipeline control: stage valid bits, per-stage load strobes and stream handshakes.
`default_nettype none

module mcpi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output mcpi_pkg::lane_ctrl_t lane_ctrl
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    // A stage loads when empty or when its word moves on
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[STAGES-1];

    assign lane_ctrl.load_prod = en[0];
    assign lane_ctrl.load_acc  = en[1];
    assign lane_ctrl.load_ctl  = en[2];
    assign lane_ctrl.load_out  = en[3];
    // integrator advances once per word leaving stage 0
    assign lane_ctrl.integ_upd = en[1] && vld_reg[0];

endmodule

`default_nettype wire
